/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property check failed");

// Check that cond is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/gsis_pkg.sv */
`default_nettype none

package gsis_pkg;

  localparam int unsigned GainWidth = 21;
  localparam int unsigned ErrWidth = 15;
  localparam int unsigned PosWidth = 16;
  localparam int unsigned DeadbandWidth = 14;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned StepWidth = PosWidth + 1;
  localparam int unsigned ProdWidth = GainWidth + ErrWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PAN_GAIN   = 3'd0,
    REG_TILT_GAIN  = 3'd1,
    REG_SLEW_LIMIT = 3'd2,
    REG_DEADBAND   = 3'd3,
    REG_PAN_LOW    = 3'd4,
    REG_PAN_HIGH   = 3'd5,
    REG_TILT_LOW   = 3'd6,
    REG_TILT_HIGH  = 3'd7
  } cfg_reg_e;

  // Per-axis settings handed to one lane.
  typedef struct packed {
    logic signed [GainWidth-1:0] gain;
    logic [PosWidth-1:0]         slew_limit;
    logic [DeadbandWidth-1:0]    deadband;
    logic [PosWidth-1:0]         low;
    logic [PosWidth-1:0]         high;
  } axis_cfg_t;

  // Pipeline strobes from the controller to the lanes.
  typedef struct packed {
    logic take;    // capture a new transaction into stage one
    logic commit;  // move stage one into the position/output register
    logic s1_full;
  } pipe_ctl_t;

endpackage

`default_nettype wire

/* rtl/gsis_lane.sv */
`default_nettype none

module gsis_lane #(
  parameter int unsigned ANGLE_FRAC_BITS = 12,
  parameter int unsigned PULSE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gsis_pkg::pipe_ctl_t                    ctl_i,
  input  gsis_pkg::axis_cfg_t                    cfg_i,
  input  logic                                   op_i,
  input  logic signed [gsis_pkg::ErrWidth-1:0]   err_i,
  input  logic [gsis_pkg::PosWidth-1:0]          value_i,
  output logic [PULSE_WIDTH-1:0]                 pos_o
);

  localparam int unsigned SumWidth = ((PULSE_WIDTH > gsis_pkg::PosWidth) ?
                                      PULSE_WIDTH : gsis_pkg::PosWidth) + 2;
  localparam int unsigned PW = gsis_pkg::ProdWidth;

  // stage one: deadband, gain, shift, slew limit
  logic signed [gsis_pkg::ErrWidth:0]      err_x;
  logic [gsis_pkg::ErrWidth:0]             mag;
  logic signed [gsis_pkg::ErrWidth-1:0]    err_eff;
  logic signed [PW-1:0]                    prod;
  logic signed [PW-1:0]                    shifted;
  logic signed [PW-1:0]                    lim_pos;
  logic signed [PW-1:0]                    lim_neg;
  logic signed [PW-1:0]                    step;

  logic                                    op_q;
  logic signed [gsis_pkg::StepWidth-1:0]   d_q;
  logic [PULSE_WIDTH-1:0]                  val_q;

  always_comb begin
    err_x   = {err_i[gsis_pkg::ErrWidth-1], err_i};
    mag     = (err_x < 0) ? $unsigned(-err_x) : $unsigned(err_x);
    err_eff = (mag < {2'b00, cfg_i.deadband}) ? '0 : err_i;
    prod    = err_eff * cfg_i.gain;
    shifted = prod >>> ANGLE_FRAC_BITS;
    lim_pos = $signed({{(PW - gsis_pkg::PosWidth){1'b0}}, cfg_i.slew_limit});
    lim_neg = -lim_pos;
    if (shifted > lim_pos) begin
      step = lim_pos;
    end else if (shifted < lim_neg) begin
      step = lim_neg;
    end else begin
      step = shifted;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      op_q  <= op_i;
      d_q   <= step[gsis_pkg::StepWidth-1:0];
      val_q <= PULSE_WIDTH'(value_i);
    end
  end

  // stage two: accumulate and clamp to the axis window
  logic signed [SumWidth-1:0] sum;
  logic signed [SumWidth-1:0] hi_x;
  logic signed [SumWidth-1:0] lo_x;
  logic signed [SumWidth-1:0] top_x;
  logic signed [SumWidth-1:0] v_hi;
  logic signed [SumWidth-1:0] v_lo;
  logic signed [SumWidth-1:0] v_sat;
  logic [PULSE_WIDTH-1:0]     pos_d;
  logic [PULSE_WIDTH-1:0]     pos_q;

  always_comb begin
    sum   = $signed({{(SumWidth - PULSE_WIDTH){1'b0}}, pos_q}) + SumWidth'(d_q);
    hi_x  = $signed({{(SumWidth - gsis_pkg::PosWidth){1'b0}}, cfg_i.high});
    lo_x  = $signed({{(SumWidth - gsis_pkg::PosWidth){1'b0}}, cfg_i.low});
    top_x = $signed({{(SumWidth - PULSE_WIDTH){1'b0}}, {PULSE_WIDTH{1'b1}}});
    v_hi  = (sum > hi_x) ? hi_x : sum;
    // low bound wins when the window is inverted
    v_lo  = (v_hi < lo_x) ? lo_x : v_hi;
    if (v_lo < 0) begin
      v_sat = '0;
    end else if (v_lo > top_x) begin
      v_sat = top_x;
    end else begin
      v_sat = v_lo;
    end
    pos_d = op_q ? val_q : v_sat[PULSE_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (ctl_i.commit) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

`default_nettype wire

/* rtl/gsis_ctrl.sv */
`default_nettype none

module gsis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gsis_pkg::pipe_ctl_t  ctl_o
);

  logic s1_valid_d, s1_valid_q;
  logic out_valid_d, out_valid_q;
  logic commit;
  logic take;

  // stage one drains whenever the output register is free or being taken
  assign commit     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !commit;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ctl_o.take    = take;
  assign ctl_o.commit  = commit;
  assign ctl_o.s1_full = s1_valid_q;

endmodule

`default_nettype wire

/* rtl/gaze_servo_increment_step_core.sv */
// Pan/tilt servo step engine.
// Input channel (in_valid_i / in_stall_o) carries one transaction per item:
// op_i = 0 steps both axes by the gain-scaled angle errors, op_i = 1 loads
// pan_value_i / tilt_value_i as the new positions. Each item yields exactly
// one result on the output channel (out_valid_o / out_stall_i) holding the
// new pan and tilt positions in sixteenths of a tick.
// An item goes through the stage-one and output registers. Throughput is one
// item per cycle unless out_stall_i holds: multiply and slew limit sit in
// stage one, and only the held position's add-and-clamp loops in stage two.
// When the receiver stalls, the result holds in the output register and one
// more item may be taken into stage one; after that in_stall_o rises.
// Reset clears both positions to zero, empties the pipeline, and sets the
// registers to gain 0, max step 65535, deadband 0, bounds 0 to 65535.
// Registers are written through cfg_we_i / cfg_index_i / cfg_data_i and are
// meant to change only while the pipeline is empty.
`default_nettype none
`include "assert_macros.svh"

module gaze_servo_increment_step_core #(
  parameter int unsigned ANGLE_FRAC_BITS = 12,
  parameter int unsigned PULSE_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [gsis_pkg::CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [gsis_pkg::GainWidth-1:0]           cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     op_i,
  input  logic signed [gsis_pkg::ErrWidth-1:0]     yaw_err_i,
  input  logic signed [gsis_pkg::ErrWidth-1:0]     pitch_err_i,
  input  logic [gsis_pkg::PosWidth-1:0]            pan_value_i,
  input  logic [gsis_pkg::PosWidth-1:0]            tilt_value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [gsis_pkg::PosWidth-1:0]            pan_pulse_o,
  output logic [gsis_pkg::PosWidth-1:0]            tilt_pulse_o
);

  gsis_pkg::axis_cfg_t pan_cfg_q, tilt_cfg_q;
  gsis_pkg::pipe_ctl_t ctl;
  logic [PULSE_WIDTH-1:0] pan_pos, tilt_pos;

  // register file; max step and deadband are shared by both lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_cfg_q.gain        <= '0;
      pan_cfg_q.slew_limit  <= '1;
      pan_cfg_q.deadband    <= '0;
      pan_cfg_q.low         <= '0;
      pan_cfg_q.high        <= '1;
      tilt_cfg_q.gain       <= '0;
      tilt_cfg_q.slew_limit <= '1;
      tilt_cfg_q.deadband   <= '0;
      tilt_cfg_q.low        <= '0;
      tilt_cfg_q.high       <= '1;
    end else if (cfg_we_i) begin
      unique case (gsis_pkg::cfg_reg_e'(cfg_index_i))
        gsis_pkg::REG_PAN_GAIN:  pan_cfg_q.gain <= $signed(cfg_data_i);
        gsis_pkg::REG_TILT_GAIN: tilt_cfg_q.gain <= $signed(cfg_data_i);
        gsis_pkg::REG_SLEW_LIMIT: begin
          pan_cfg_q.slew_limit  <= cfg_data_i[gsis_pkg::PosWidth-1:0];
          tilt_cfg_q.slew_limit <= cfg_data_i[gsis_pkg::PosWidth-1:0];
        end
        gsis_pkg::REG_DEADBAND: begin
          pan_cfg_q.deadband  <= cfg_data_i[gsis_pkg::DeadbandWidth-1:0];
          tilt_cfg_q.deadband <= cfg_data_i[gsis_pkg::DeadbandWidth-1:0];
        end
        gsis_pkg::REG_PAN_LOW:   pan_cfg_q.low <= cfg_data_i[gsis_pkg::PosWidth-1:0];
        gsis_pkg::REG_PAN_HIGH:  pan_cfg_q.high <= cfg_data_i[gsis_pkg::PosWidth-1:0];
        gsis_pkg::REG_TILT_LOW:  tilt_cfg_q.low <= cfg_data_i[gsis_pkg::PosWidth-1:0];
        gsis_pkg::REG_TILT_HIGH: tilt_cfg_q.high <= cfg_data_i[gsis_pkg::PosWidth-1:0];
        default: ;
      endcase
    end
  end

  gsis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  gsis_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .PULSE_WIDTH     (PULSE_WIDTH)
  ) u_pan_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .cfg_i   (pan_cfg_q),
    .op_i    (op_i),
    .err_i   (yaw_err_i),
    .value_i (pan_value_i),
    .pos_o   (pan_pos)
  );

  gsis_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .PULSE_WIDTH     (PULSE_WIDTH)
  ) u_tilt_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .cfg_i   (tilt_cfg_q),
    .op_i    (op_i),
    .err_i   (pitch_err_i),
    .value_i (tilt_value_i),
    .pos_o   (tilt_pos)
  );

  // merge both lanes into one result transaction
  assign pan_pulse_o  = gsis_pkg::PosWidth'(pan_pos);
  assign tilt_pulse_o = gsis_pkg::PosWidth'(tilt_pos);

  `ASSERT_PROP(a_stall_full, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i && ctl.s1_full))
  `ASSERT_PROP(a_out_drains, clk_i, rst_ni, (out_valid_o && !out_stall_i && !ctl.s1_full) |=> !out_valid_o)
  `ASSERT_PROP(a_out_from_s1, clk_i, rst_ni, $rose(out_valid_o) |-> $past(ctl.s1_full))
  `ASSERT_NEVER(a_commit_empty, clk_i, rst_ni, ctl.commit && !ctl.s1_full)

endmodule

`default_nettype wire
